[rtl/psort_pkg.sv]
// Shared constants and types for the patience sorter.
`timescale 1ns / 1ps
`default_nettype none

package psort_pkg;

   localparam int MAX_ITEMS = 32;
   localparam int VALUE_W   = 32;
   localparam int SLOT_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [SLOT_W-1:0]         slot_type;
   typedef logic [CNT_W-1:0]          count_type;

endpackage

`default_nettype wire

[rtl/psort_min.sv]
// Two-stage registered minimum tree over the pile tops, ties to the lowest pile.
`timescale 1ns / 1ps
`default_nettype none

module psort_min
   import psort_pkg::*;
(
   input  wire logic              clock,
   input  wire value_type         tops [MAX_ITEMS],
   input  wire logic [MAX_ITEMS-1:0] live,
   output slot_type               best
);

   localparam int LEAVES = 1 << SLOT_W;
   localparam int MIDS   = LEAVES / 4;
   localparam int LEVELS = SLOT_W - 2;

   typedef struct packed {
      logic      live;
      value_type val;
      slot_type  idx;
   } cand_type;

   cand_type leaf_c  [LEAVES];
   cand_type half_c  [LEAVES/2];
   cand_type mid_in  [MIDS];
   cand_type mid_ff  [MIDS];
   cand_type tree_c  [LEVELS+1][MIDS];
   slot_type best_in;
   slot_type best_ff;

   function automatic cand_type pick(input cand_type a, input cand_type b);
      if (a.live && (!b.live || $signed(a.val) <= $signed(b.val))) begin
         return a;
      end
      return b;
   endfunction

   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         leaf_c[i].idx = SLOT_W'(i);
         if (i < MAX_ITEMS) begin
            leaf_c[i].live = live[i];
            leaf_c[i].val  = tops[i];
         end else begin
            leaf_c[i].live = 1'b0;
            leaf_c[i].val  = '0;
         end
      end
      for (int i = 0; i < LEAVES/2; i++) begin
         half_c[i] = pick(leaf_c[2*i], leaf_c[2*i+1]);
      end
      for (int i = 0; i < MIDS; i++) begin
         mid_in[i] = pick(half_c[2*i], half_c[2*i+1]);
      end
   end

   always_comb begin
      for (int l = 0; l <= LEVELS; l++) begin
         for (int i = 0; i < MIDS; i++) begin
            tree_c[l][i] = '0;
         end
      end
      for (int i = 0; i < MIDS; i++) begin
         tree_c[0][i] = mid_ff[i];
      end
      for (int l = 1; l <= LEVELS; l++) begin
         for (int i = 0; i < (MIDS >> l); i++) begin
            tree_c[l][i] = pick(tree_c[l-1][2*i], tree_c[l-1][2*i+1]);
         end
      end
      best_in = tree_c[LEVELS][0].idx;
   end

   always_ff @(posedge clock) begin
      mid_ff  <= mid_in;
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule

`default_nettype wire

[rtl/patience_sort.sv]
// Patience sorter top level: pile dealing, link memory and merge sequencer.
//
// Usage:
//   Input: drive req_value and req_last with start high; a word is taken at a
//   rising edge where start is high and busy is low. After each accept,
//   ST_LOAD compares all pile tops in parallel and, if the run is not full,
//   writes the link memory, so busy is high for the cycle after every accept.
//   A word with req_last high is loaded and then starts the merge.
//   Output: each sorted word is shown for one cycle with rsp_valid high. The
//   merge steps through ST_MSEL and ST_MTREE (registered minimum tree over the
//   pile tops), ST_MREAD (link memory read) and ST_MPOP (pile pop) per word.
//   The first word is registered out after the last word passes ST_LOAD, ST_MSEL,
//   ST_MTREE and ST_MREAD; rsp_end_of_run marks the largest one. busy stays high
//   until the run is done. Up to 32 words are kept per run; more are discarded and
//   rsp_dropped is high on every word of that run.
//   The receiver cannot stall; every strobed word is taken.
//   Reset (synchronous, active high) empties the sorter; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module patience_sort
   import psort_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   output logic           busy,
   input  wire value_type req_value,
   input  wire logic      req_last,
   output logic           rsp_valid,
   output value_type      rsp_sorted_value,
   output logic           rsp_end_of_run,
   output logic           rsp_dropped
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_MSEL  = 6'b000100,
      ST_MTREE = 6'b001000,
      ST_MREAD = 6'b010000,
      ST_MPOP  = 6'b100000
   } state_type;

   typedef struct packed {
      slot_type  slot;
      value_type val;
   } link_type;

   state_type state_ff, state_in;
   value_type load_val_ff, load_val_in;
   logic      load_last_ff, load_last_in;
   count_type pile_count_ff, pile_count_in;
   count_type elem_count_ff, elem_count_in;
   logic      overflow_ff, overflow_in;

   value_type top_val_ff  [MAX_ITEMS];
   value_type top_val_in  [MAX_ITEMS];
   slot_type  top_slot_ff [MAX_ITEMS];
   slot_type  top_slot_in [MAX_ITEMS];
   count_type height_ff   [MAX_ITEMS];
   count_type height_in   [MAX_ITEMS];

   link_type  link_mem [MAX_ITEMS];
   link_type  rd_data_ff;
   logic      mem_we;
   slot_type  mem_waddr;
   link_type  mem_wdata;

   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff, rsp_value_in;
   logic      rsp_eor_ff, rsp_eor_in;
   logic      rsp_drop_ff, rsp_drop_in;

   logic [MAX_ITEMS-1:0] live;
   logic [MAX_ITEMS-1:0] fits;
   count_type target;
   slot_type  tgt;
   logic      new_pile;
   slot_type  best;

   psort_min u_min (
      .clock (clock),
      .tops  (top_val_ff),
      .live  (live),
      .best  (best)
   );

   always_comb begin
      for (int p = 0; p < MAX_ITEMS; p++) begin
         live[p] = CNT_W'(p) < pile_count_ff;
         fits[p] = live[p] && (load_val_ff < top_val_ff[p]);
      end
      target = pile_count_ff;
      for (int p = MAX_ITEMS - 1; p >= 0; p--) begin
         if (fits[p]) begin
            target = CNT_W'(p);
         end
      end
      tgt      = target[SLOT_W-1:0];
      new_pile = target == pile_count_ff;
   end

   always_comb begin
      state_in      = state_ff;
      load_val_in   = load_val_ff;
      load_last_in  = load_last_ff;
      pile_count_in = pile_count_ff;
      elem_count_in = elem_count_ff;
      overflow_in   = overflow_ff;
      top_val_in    = top_val_ff;
      top_slot_in   = top_slot_ff;
      height_in     = height_ff;
      mem_we        = 1'b0;
      mem_waddr     = elem_count_ff[SLOT_W-1:0];
      mem_wdata     = '{slot: top_slot_ff[tgt], val: top_val_ff[tgt]};
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_eor_in    = rsp_eor_ff;
      rsp_drop_in   = rsp_drop_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               load_val_in  = req_value;
               load_last_in = req_last;
               state_in     = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (elem_count_ff == CNT_W'(MAX_ITEMS)) begin
               overflow_in = 1'b1;
            end else begin
               mem_we           = 1'b1;
               top_val_in[tgt]  = load_val_ff;
               top_slot_in[tgt] = elem_count_ff[SLOT_W-1:0];
               elem_count_in    = elem_count_ff + CNT_W'(1);
               if (new_pile) begin
                  height_in[tgt] = CNT_W'(1);
                  pile_count_in  = pile_count_ff + CNT_W'(1);
               end else begin
                  height_in[tgt] = height_ff[tgt] + CNT_W'(1);
               end
            end
            state_in = load_last_ff ? ST_MSEL : ST_IDLE;
         end
         ST_MSEL: begin
            state_in = ST_MTREE;
         end
         ST_MTREE: begin
            state_in = ST_MREAD;
         end
         ST_MREAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = top_val_ff[best];
            rsp_eor_in   = (pile_count_ff == CNT_W'(1)) && (height_ff[best] == CNT_W'(1));
            rsp_drop_in  = overflow_ff;
            state_in     = ST_MPOP;
         end
         ST_MPOP: begin
            if (height_ff[best] > CNT_W'(1)) begin
               top_val_in[best]  = rd_data_ff.val;
               top_slot_in[best] = rd_data_ff.slot;
               height_in[best]   = height_ff[best] - CNT_W'(1);
               state_in          = ST_MSEL;
            end else begin
               for (int p = 0; p < MAX_ITEMS - 1; p++) begin
                  if (SLOT_W'(p) >= best) begin
                     top_val_in[p]  = top_val_ff[p+1];
                     top_slot_in[p] = top_slot_ff[p+1];
                     height_in[p]   = height_ff[p+1];
                  end
               end
               pile_count_in = pile_count_ff - CNT_W'(1);
               if (pile_count_ff == CNT_W'(1)) begin
                  elem_count_in = '0;
                  overflow_in   = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_MSEL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pile_count_ff <= '0;
         elem_count_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pile_count_ff <= pile_count_in;
         elem_count_ff <= elem_count_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      load_val_ff  <= load_val_in;
      load_last_ff <= load_last_in;
      top_val_ff   <= top_val_in;
      top_slot_ff  <= top_slot_in;
      height_ff    <= height_in;
      rsp_value_ff <= rsp_value_in;
      rsp_eor_ff   <= rsp_eor_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= link_mem[top_slot_ff[best]];
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_run   = rsp_eor_ff;
   assign rsp_dropped      = rsp_drop_ff;

endmodule

`default_nettype wire
